FILE: rtl/core/iso14a_pkg.sv
// Package: shared types and constants for the type A selection sequencer.
`timescale 1ns / 1ps
package iso14a_pkg;

  localparam int UID_MAX = 10;
  localparam int UID_CNT_W = 4;

  localparam logic [3:0] NVB_ANTICOLL_NIBBLE = 4'h2;
  localparam logic [3:0] NVB_SELECT_NIBBLE   = 4'h7;
  localparam logic [7:0] NVB_ANTICOLL        = {NVB_ANTICOLL_NIBBLE, 4'h0};
  localparam logic [7:0] NVB_SELECT          = {NVB_SELECT_NIBBLE, 4'h0};
  localparam logic [15:0] ATQA_ANTICOLL_MASK = 16'h001f;
  localparam int SAK_CASCADE_POS = 2;  // bit of 0x04
  localparam logic [7:0] CASCADE_TAG     = 8'h88;
  localparam logic [7:0] LEVEL_CODE_BASE = 8'h93;
  localparam logic [1:0] LAST_LEVEL      = 2'd2;

  localparam logic [2:0] LEN_ATQA = 3'd2;
  localparam logic [2:0] LEN_UID  = 3'd5;
  localparam logic [2:0] LEN_SAK  = 3'd1;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_REPLY = 1'b1;

  localparam logic [1:0] KIND_WUPA     = 2'd0;
  localparam logic [1:0] KIND_ANTICOLL = 2'd1;
  localparam logic [1:0] KIND_SELECT   = 2'd2;
  localparam logic [1:0] KIND_FINISHED = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_PROTO = 2'd1;
  localparam logic [1:0] STATUS_XCVR  = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ATQA,
    PH_ANTICOLL,
    PH_SAK
  } phase_t;

  typedef logic [UID_MAX-1:0][7:0] uid_t;

  typedef struct packed {
    logic        action;
    logic        rx_status;
    logic [2:0]  rx_len;
    logic [39:0] rx_data;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_level_code;
    logic [7:0]  tx_nvb;
    logic [39:0] tx_payload;
    logic [1:0]  status;
    logic [15:0] atqa;
    logic [7:0]  sak;
    logic [3:0]  uid_len;
    logic [63:0] uid_low;
    logic [15:0] uid_high;
  } res_t;

  typedef struct packed {
    phase_t                 phase;
    logic [1:0]             cascade_level;
    logic [UID_CNT_W-1:0]   uid_count;
    logic                   tag_seen;
    logic [15:0]            saved_atqa;
    logic [7:0]             saved_sak;
  } ctx_t;

endpackage

FILE: rtl/core/iso14a_ifs.sv
// Interfaces: request channel and result channel of the selection sequencer.
`timescale 1ns / 1ps
interface iso14a_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic        rx_status;
  logic [2:0]  rx_len;
  logic [39:0] rx_data;

  modport source(output valid, action, rx_status, rx_len, rx_data, input ready);
  modport sink(input valid, action, rx_status, rx_len, rx_data, output ready);
endinterface

interface iso14a_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  tx_level_code;
  logic [7:0]  tx_nvb;
  logic [39:0] tx_payload;
  logic [1:0]  status;
  logic [15:0] atqa;
  logic [7:0]  sak;
  logic [3:0]  uid_len;
  logic [63:0] uid_low;
  logic [15:0] uid_high;

  modport source(output valid, kind, tx_level_code, tx_nvb, tx_payload, status, atqa, sak,
                 uid_len, uid_low, uid_high, input ready);
  modport sink(input valid, kind, tx_level_code, tx_nvb, tx_payload, status, atqa, sak,
               uid_len, uid_low, uid_high, output ready);
endinterface

FILE: rtl/core/iso14a_step.sv
// Step logic: next sequencer state, UID store and result for one request.
`timescale 1ns / 1ps
module iso14a_step import iso14a_pkg::*; (
  input  req_t ireq,
  input  ctx_t ctx,
  input  uid_t uid,
  output ctx_t ctx_next,
  output uid_t uid_next,
  output logic emit,
  output res_t result
);

  logic [3:0][7:0]      id4;
  logic                 fin;
  logic [1:0]           fin_status;
  logic                 send_wupa;
  logic                 send_ac;
  logic                 send_sel;
  logic                 skip;
  logic                 casc;
  logic [UID_CNT_W-1:0] off;
  logic [UID_CNT_W-1:0] pos;
  logic [UID_CNT_W-1:0] cnt_sum;
  logic [7:0]           level_code;

  assign id4 = ireq.rx_data[31:0];

  always_comb begin
    ctx_next   = ctx;
    uid_next   = uid;
    fin        = 1'b0;
    fin_status = STATUS_OK;
    send_wupa  = 1'b0;
    send_ac    = 1'b0;
    send_sel   = 1'b0;
    skip       = 1'b0;
    casc       = 1'b0;
    off        = '0;
    pos        = '0;
    cnt_sum    = '0;
    if (ireq.action == ACT_START) begin
      ctx_next       = '0;
      ctx_next.phase = PH_ATQA;
      uid_next       = '0;
      send_wupa      = 1'b1;
    end else if (ctx.phase != PH_IDLE) begin
      if (ireq.rx_status) begin
        fin        = 1'b1;
        fin_status = STATUS_XCVR;
      end else begin
        case (ctx.phase)
          PH_ATQA: begin
            if (ireq.rx_len != LEN_ATQA) begin
              fin        = 1'b1;
              fin_status = STATUS_PROTO;
            end else begin
              ctx_next.saved_atqa = ireq.rx_data[15:0];
              if ((ireq.rx_data[15:0] & ATQA_ANTICOLL_MASK) == '0) begin
                fin        = 1'b1;
                fin_status = STATUS_PROTO;
              end else begin
                ctx_next.cascade_level = '0;
                send_ac                = 1'b1;
              end
            end
          end
          PH_ANTICOLL: begin
            if (ireq.rx_len != LEN_UID ||
                (id4[0] ^ id4[1] ^ id4[2] ^ id4[3]) != ireq.rx_data[39:32]) begin
              fin        = 1'b1;
              fin_status = STATUS_PROTO;
            end else begin
              skip              = (id4[0] == CASCADE_TAG);
              ctx_next.tag_seen = skip;
              // each store entry picks its byte from the frame, if it falls in range
              for (int j = 0; j < UID_MAX; j++) begin
                off = UID_CNT_W'(j) - ctx.uid_count;
                pos = off + UID_CNT_W'(skip);
                if (UID_CNT_W'(j) >= ctx.uid_count && pos <= UID_CNT_W'(3)) begin
                  uid_next[j] = id4[pos[1:0]];
                end
              end
              cnt_sum = ctx.uid_count + UID_CNT_W'(4) - UID_CNT_W'(skip);
              ctx_next.uid_count = (cnt_sum > UID_CNT_W'(UID_MAX)) ?
                                   UID_CNT_W'(UID_MAX) : cnt_sum;
              send_sel = 1'b1;
            end
          end
          PH_SAK: begin
            if (ireq.rx_len != LEN_SAK) begin
              fin        = 1'b1;
              fin_status = STATUS_PROTO;
            end else begin
              ctx_next.saved_sak = ireq.rx_data[7:0];
              casc = ireq.rx_data[SAK_CASCADE_POS];
              if (casc != ctx.tag_seen) begin
                fin        = 1'b1;
                fin_status = STATUS_PROTO;
              end else if (!casc) begin
                fin        = 1'b1;
                fin_status = STATUS_OK;
              end else if (ctx.cascade_level >= LAST_LEVEL) begin
                fin        = 1'b1;
                fin_status = STATUS_PROTO;
              end else begin
                ctx_next.cascade_level = ctx.cascade_level + 2'd1;
                send_ac                = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
    end
    if (fin)      ctx_next.phase = PH_IDLE;
    if (send_ac)  ctx_next.phase = PH_ANTICOLL;
    if (send_sel) ctx_next.phase = PH_SAK;
  end

  assign level_code = LEVEL_CODE_BASE + {5'b0, ctx_next.cascade_level, 1'b0};
  assign emit = fin | send_wupa | send_ac | send_sel;

  always_comb begin
    result               = '0;
    result.atqa          = ctx_next.saved_atqa;
    result.sak           = ctx_next.saved_sak;
    result.uid_len       = ctx_next.uid_count;
    result.uid_low       = uid_next[7:0];
    result.uid_high      = uid_next[9:8];
    if (fin) begin
      result.kind   = KIND_FINISHED;
      result.status = fin_status;
    end else if (send_ac) begin
      result.kind          = KIND_ANTICOLL;
      result.tx_level_code = level_code;
      result.tx_nvb        = NVB_ANTICOLL;
    end else if (send_sel) begin
      result.kind          = KIND_SELECT;
      result.tx_level_code = level_code;
      result.tx_nvb        = NVB_SELECT;
      result.tx_payload    = ireq.rx_data;
    end else begin
      result.kind = KIND_WUPA;
    end
  end

endmodule

FILE: rtl/core/iso14a_res_reg.sv
// Result register: holds one result until the sink takes it.
`timescale 1ns / 1ps
module iso14a_res_reg import iso14a_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  res_t d,
  output logic free,
  iso14a_res_if.source res
);

  logic valid;
  res_t q;

  assign free = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= d;
    end
  end

  assign res.valid         = valid;
  assign res.kind          = q.kind;
  assign res.tx_level_code = q.tx_level_code;
  assign res.tx_nvb        = q.tx_nvb;
  assign res.tx_payload    = q.tx_payload;
  assign res.status        = q.status;
  assign res.atqa          = q.atqa;
  assign res.sak           = q.sak;
  assign res.uid_len       = q.uid_len;
  assign res.uid_low       = q.uid_low;
  assign res.uid_high      = q.uid_high;

endmodule

FILE: rtl/core/iso14443a_anticollision_reader.sv
// Top level: ISO 14443-3 type A reader-side WUPA / anticollision / select sequencer.
// Flow: a request is registered in the input stage on acceptance, and its result is
//   registered in the result register when the request leaves that stage.
// Throughput: one request per cycle; the single step unit between the input and result
//   registers sets this, stalling only while the result register is full and not taken.
// Reset (rst, synchronous, active high): sequencer idle, UID store, count and saved
//   ATQA/SAK cleared, both register stages empty.
`timescale 1ns / 1ps
module iso14443a_anticollision_reader import iso14a_pkg::*; (
  input  logic clk,
  input  logic rst,
  iso14a_req_if.sink   req,
  iso14a_res_if.source res
);

  // input stage: one buffered request
  logic in_valid;
  req_t in_q;

  // sequencer state and UID store
  ctx_t ctx;
  ctx_t ctx_next;
  uid_t uid;
  uid_t uid_next;

  logic emit;
  res_t result;
  logic res_free;
  logic fire;

  // A request advances when it makes no result or the result register has room.
  // Replies while idle make no result and just drain.
  assign fire      = in_valid && (!emit || res_free);
  assign req.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_q <= '{action: req.action, rx_status: req.rx_status,
                rx_len: req.rx_len, rx_data: req.rx_data};
    end
  end

  // state commits only when the request leaves the input stage
  // (all-zero context is the idle phase)
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx <= '0;
      uid <= '0;
    end else if (fire) begin
      ctx <= ctx_next;
      uid <= uid_next;
    end
  end

  iso14a_step u_step (
    .ireq     (in_q),
    .ctx      (ctx),
    .uid      (uid),
    .ctx_next (ctx_next),
    .uid_next (uid_next),
    .emit     (emit),
    .result   (result)
  );

  iso14a_res_reg u_res_reg (
    .clk  (clk),
    .rst  (rst),
    .load (fire && emit),
    .d    (result),
    .free (res_free),
    .res  (res)
  );

endmodule

FILE: rtl/core/iso14a_checker.sv
// Checker: port-level properties of the selection sequencer, bound to the top level.
`timescale 1ns / 1ps
module iso14a_checker import iso14a_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  kind,
  input logic [7:0]  tx_level_code,
  input logic [7:0]  tx_nvb,
  input logic [1:0]  status,
  input logic [15:0] atqa,
  input logic [7:0]  sak,
  input logic [3:0]  uid_len
);

  // a stalled result holds its contents
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(status) &&
      $stable(uid_len))
    else $error("result changed while stalled");

  // a WUPA request always follows a full clear
  a_wupa_clear: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_WUPA |->
      status == STATUS_OK && uid_len == '0 && atqa == '0 && sak == '0 &&
      tx_nvb == '0 && tx_level_code == '0)
    else $error("WUPA request with stale state");

  // only a finished result carries a nonzero status
  a_status_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind != KIND_FINISHED |-> status == STATUS_OK)
    else $error("status set on a non-final result");

  // frame requests carry a legal level code and matching NVB
  a_frame_codes: assert property (@(posedge clk) disable iff (rst)
    res_valid && (kind == KIND_ANTICOLL || kind == KIND_SELECT) |->
      (tx_level_code == 8'h93 || tx_level_code == 8'h95 || tx_level_code == 8'h97) &&
      (kind == KIND_ANTICOLL ? tx_nvb == NVB_ANTICOLL : tx_nvb == NVB_SELECT))
    else $error("bad level code or NVB");

  // UID count never passes the store size
  a_uid_len: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> uid_len <= 4'(UID_MAX))
    else $error("UID length out of range");

endmodule

bind iso14443a_anticollision_reader iso14a_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .kind          (res.kind),
  .tx_level_code (res.tx_level_code),
  .tx_nvb        (res.tx_nvb),
  .status        (res.status),
  .atqa          (res.atqa),
  .sak           (res.sak),
  .uid_len       (res.uid_len)
);
